>>> rtl/csched_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter task scheduler package
// Shared constants, codes, slot record and helper functions.
// ----------------------------------------------------------------------------
package csched_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LIFE_W    = 16;
    localparam int PRIO_W    = 8;

    localparam logic signed [LIFE_W-1:0] LIFE_MIN  = {1'b1, {(LIFE_W-1){1'b0}}};
    localparam logic signed [LIFE_W-1:0] LIFE_NONE = '1;

    localparam logic [1:0] RUN_RUNNING = 2'd0;
    localparam logic [1:0] RUN_ZOMBIE  = 2'd1;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_RESCHED     = 3'd1,
        CMD_EXIT        = 3'd2,
        CMD_PREEMPT_EN  = 3'd3,
        CMD_PREEMPT_DIS = 3'd4,
        CMD_INSTALL     = 3'd5
    } cmd_t;

    typedef enum logic [0:0] {
        ALU_DEC,
        ALU_RECHARGE
    } alu_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR,
        S_SCAN,
        S_RECHARGE,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                     present;
        logic [1:0]               run_state;
        logic [PRIO_W-1:0]        priority_val;
        logic signed [LIFE_W-1:0] lifetime;
        logic                     preempt;
    } slot_t;

    typedef struct packed {
        logic present;
        logic run_state;
        logic priority_val;
        logic lifetime;
        logic preempt;
    } tbl_wr_t;

    // Maps the 4-bit slot field of an item onto a table address.
    function automatic logic [SLOT_W-1:0] addr_from_field(input logic [3:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[SLOT_W-1:0];
    endfunction

    // Maps a table address onto the 4-bit slot field of a result.
    function automatic logic [3:0] field_from_addr(input logic [SLOT_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/csched_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter task scheduler channels
// Valid/ready interfaces for command items and status items.
// ----------------------------------------------------------------------------
interface csched_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [3:0] slot_index;
    logic       slot_present;
    logic [1:0] slot_run_state;
    logic [7:0] slot_priority;
    logic [8:0] slot_lifetime;

    modport source (
        output valid, cmd, slot_index, slot_present, slot_run_state,
               slot_priority, slot_lifetime,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot_index, slot_present, slot_run_state,
               slot_priority, slot_lifetime,
        output ready
    );
endinterface

interface csched_rsp_if;
    logic               valid;
    logic               ready;
    logic [3:0]         current_slot;
    logic               switched;
    logic signed [15:0] current_lifetime;
    logic               current_preemptable;

    modport source (
        output valid, current_slot, switched, current_lifetime, current_preemptable,
        input  ready
    );
    modport sink (
        input  valid, current_slot, switched, current_lifetime, current_preemptable,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/csched_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table
// Per-slot task state with one shared address for reading and writing.
// ----------------------------------------------------------------------------
module csched_table
    import csched_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] addr,
    input  wire tbl_wr_t           wr,
    input  wire slot_t             wdata,
    output slot_t                  rdata
);

    logic                     present_reg  [NUM_SLOTS];
    logic [1:0]               run_reg      [NUM_SLOTS];
    logic [PRIO_W-1:0]        prio_reg     [NUM_SLOTS];
    logic signed [LIFE_W-1:0] life_reg     [NUM_SLOTS];
    logic                     preempt_reg  [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                present_reg[i] <= (i == 0);
                run_reg[i]     <= RUN_RUNNING;
                prio_reg[i]    <= PRIO_W'(1);
                life_reg[i]    <= '0;
                preempt_reg[i] <= (i == 0);
            end
        end
        else
        begin
            if (wr.present)
            begin
                present_reg[addr] <= wdata.present;
            end
            if (wr.run_state)
            begin
                run_reg[addr] <= wdata.run_state;
            end
            if (wr.priority_val)
            begin
                prio_reg[addr] <= wdata.priority_val;
            end
            if (wr.lifetime)
            begin
                life_reg[addr] <= wdata.lifetime;
            end
            if (wr.preempt)
            begin
                preempt_reg[addr] <= wdata.preempt;
            end
        end
    end

    always_comb
    begin
        rdata.present      = present_reg[addr];
        rdata.run_state    = run_reg[addr];
        rdata.priority_val = prio_reg[addr];
        rdata.lifetime     = life_reg[addr];
        rdata.preempt      = preempt_reg[addr];
    end

endmodule

`default_nettype wire

>>> rtl/csched_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lifetime unit
// Shared saturating decrement, recharge and compare against the running best.
// ----------------------------------------------------------------------------
module csched_alu
    import csched_pkg::*;
(
    input  wire alu_op_t                  op,
    input  wire logic signed [LIFE_W-1:0] lifetime,
    input  wire logic [PRIO_W-1:0]        prio,
    input  wire logic signed [LIFE_W-1:0] best,
    output logic signed [LIFE_W-1:0]      result,
    output logic                          greater
);

    logic signed [LIFE_W-1:0] halved;
    logic signed [LIFE_W:0]   sum;

    always_comb
    begin
        // An arithmetic shift gives the floor of half for negative values too.
        halved = lifetime >>> 1;
        sum    = {halved[LIFE_W-1], halved} + $signed({{(LIFE_W + 1 - PRIO_W){1'b0}}, prio});
        unique case (op)
            ALU_DEC:
            begin
                result = (lifetime == LIFE_MIN) ? lifetime : lifetime - LIFE_W'(1);
            end
            ALU_RECHARGE:
            begin
                result = sum[LIFE_W-1:0];
            end
            default:
            begin
                result = lifetime;
            end
        endcase
        greater = lifetime > best;
    end

endmodule

`default_nettype wire

>>> rtl/counter_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter task scheduler
// Command channel in, one status item out per command.
// ----------------------------------------------------------------------------
// Each command item on req produces exactly one status item on rsp giving the
// current slot, whether it changed, and its lifetime and preempt flag.
// The block takes one item at a time: req.ready is high only while idle.
// Preempt, install, unused codes and a tick that does not expire go from the
// execute state straight to the result. A reschedule clears the current slot,
// walks the slot table one slot per cycle through the shared lifetime unit and
// commits the pick; when the largest runnable lifetime is zero, one recharge
// pass plus a second search follow the first search. The single table port
// sets this pace. The next item can be accepted in the cycle after the result
// is registered.
// The result sits in an output register; a new item is accepted while it
// waits, and the block holds in its final state until rsp frees the register.
// Reset clears the table to slot 0 present and current with its preempt flag
// set, all priorities one and all lifetimes zero, and empties the output.
// ----------------------------------------------------------------------------
module counter_task_scheduler
    import csched_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    csched_req_if.sink   req,
    csched_rsp_if.source rsp
);

    state_t             state_reg, state_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic [3:0]         idx_reg, idx_next;
    logic               pres_reg, pres_next;
    logic [1:0]         run_reg, run_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [8:0]         life_reg, life_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  prev_reg, prev_next;
    logic [SLOT_W-1:0]  scan_reg, scan_next;
    logic [SLOT_W-1:0]  pick_reg, pick_next;
    logic signed [LIFE_W-1:0] best_reg, best_next;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_slot_reg, out_slot_next;
    logic               out_sw_reg, out_sw_next;
    logic signed [LIFE_W-1:0] out_life_reg, out_life_next;
    logic               out_pre_reg, out_pre_next;

    logic [SLOT_W-1:0]  tbl_addr;
    tbl_wr_t            tbl_wr;
    slot_t              tbl_wdata;
    slot_t              tbl_rdata;

    alu_op_t                  alu_op;
    logic signed [LIFE_W-1:0] alu_result;
    logic                     alu_greater;

    logic               scan_last;
    logic               install_ok;
    logic               candidate;
    logic signed [LIFE_W-1:0] best_cand;
    logic [SLOT_W-1:0]  pick_cand;

    csched_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (tbl_addr),
        .wr    (tbl_wr),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    csched_alu u_alu (
        .op       (alu_op),
        .lifetime (tbl_rdata.lifetime),
        .prio     (tbl_rdata.priority_val),
        .best     (best_reg),
        .result   (alu_result),
        .greater  (alu_greater)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        pres_reg     <= pres_next;
        run_reg      <= run_next;
        prio_reg     <= prio_next;
        life_reg     <= life_next;
        prev_reg     <= prev_next;
        scan_reg     <= scan_next;
        pick_reg     <= pick_next;
        best_reg     <= best_next;
        out_slot_reg <= out_slot_next;
        out_sw_reg   <= out_sw_next;
        out_life_reg <= out_life_next;
        out_pre_reg  <= out_pre_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        pres_next      = pres_reg;
        run_next       = run_reg;
        prio_next      = prio_reg;
        life_next      = life_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        scan_next      = scan_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_slot_next  = out_slot_reg;
        out_sw_next    = out_sw_reg;
        out_life_next  = out_life_reg;
        out_pre_next   = out_pre_reg;

        req.ready = 1'b0;
        tbl_addr  = cur_reg;
        tbl_wr    = '0;
        tbl_wdata = tbl_rdata;
        alu_op    = ALU_DEC;

        scan_last  = scan_reg == SLOT_W'(NUM_SLOTS - 1);
        install_ok = 32'(idx_reg) < 32'(NUM_SLOTS);
        candidate  = tbl_rdata.present && (tbl_rdata.run_state == RUN_RUNNING) && alu_greater;
        best_cand  = candidate ? tbl_rdata.lifetime : best_reg;
        pick_cand  = candidate ? scan_reg : pick_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    idx_next   = req.slot_index;
                    pres_next  = req.slot_present;
                    run_next   = req.slot_run_state;
                    prio_next  = req.slot_priority;
                    life_next  = req.slot_lifetime;
                    prev_next  = cur_reg;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        alu_op             = ALU_DEC;
                        tbl_wdata.lifetime = alu_result;
                        tbl_wr.lifetime    = 1'b1;
                        if ((alu_result <= 0) && tbl_rdata.preempt)
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                    CMD_RESCHED:
                    begin
                        state_next = S_CLEAR;
                    end
                    CMD_EXIT:
                    begin
                        tbl_wdata.run_state = RUN_ZOMBIE;
                        tbl_wr.run_state    = 1'b1;
                        state_next          = S_CLEAR;
                    end
                    CMD_PREEMPT_EN:
                    begin
                        tbl_wdata.preempt = 1'b1;
                        tbl_wr.preempt    = 1'b1;
                    end
                    CMD_PREEMPT_DIS:
                    begin
                        tbl_wdata.preempt = 1'b0;
                        tbl_wr.preempt    = 1'b1;
                    end
                    CMD_INSTALL:
                    begin
                        tbl_addr               = addr_from_field(idx_reg);
                        tbl_wdata.present      = pres_reg;
                        tbl_wdata.run_state    = run_reg;
                        tbl_wdata.priority_val = (prio_reg == '0) ? PRIO_W'(1) : prio_reg;
                        tbl_wdata.lifetime     = $signed({{(LIFE_W - 9){1'b0}}, life_reg});
                        tbl_wr.present         = install_ok;
                        tbl_wr.run_state       = install_ok;
                        tbl_wr.priority_val    = install_ok;
                        tbl_wr.lifetime        = install_ok;
                    end
                    default:
                    begin
                        // Unused command codes leave the state alone.
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CLEAR:
            begin
                tbl_wdata.lifetime = '0;
                tbl_wdata.preempt  = 1'b0;
                tbl_wr.lifetime    = 1'b1;
                tbl_wr.preempt     = 1'b1;
                scan_next          = '0;
                best_next          = LIFE_NONE;
                pick_next          = '0;
                state_next         = S_SCAN;
            end

            S_SCAN:
            begin
                tbl_addr  = scan_reg;
                best_next = best_cand;
                pick_next = pick_cand;
                scan_next = scan_reg + SLOT_W'(1);
                if (scan_last)
                begin
                    scan_next = '0;
                    // A best lifetime of zero means every runnable slot is spent.
                    state_next = (best_cand == '0) ? S_RECHARGE : S_COMMIT;
                end
            end

            S_RECHARGE:
            begin
                tbl_addr           = scan_reg;
                alu_op             = ALU_RECHARGE;
                tbl_wdata.lifetime = alu_result;
                tbl_wr.lifetime    = tbl_rdata.present;
                scan_next          = scan_reg + SLOT_W'(1);
                if (scan_last)
                begin
                    scan_next  = '0;
                    best_next  = LIFE_NONE;
                    pick_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_COMMIT:
            begin
                tbl_addr          = pick_reg;
                tbl_wdata.preempt = 1'b1;
                tbl_wr.preempt    = 1'b1;
                cur_next          = pick_reg;
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = field_from_addr(cur_reg);
                    out_sw_next    = cur_reg != prev_reg;
                    out_life_next  = tbl_rdata.lifetime;
                    out_pre_next   = tbl_rdata.preempt;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.current_slot        = out_slot_reg;
    assign rsp.switched            = out_sw_reg;
    assign rsp.current_lifetime    = out_life_reg;
    assign rsp.current_preemptable = out_pre_reg;

endmodule

`default_nettype wire

>>> rtl/csched_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Counter task scheduler checker
// Port-level properties of the scheduler, attached by bind.
// ----------------------------------------------------------------------------
module csched_checker
    import csched_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               req_valid,
    input wire logic               req_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [3:0]         rsp_slot,
    input wire logic               rsp_switched,
    input wire logic signed [15:0] rsp_lifetime,
    input wire logic               rsp_preempt
);

    // A waiting status item keeps its contents until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
            && $stable(rsp_switched) && $stable(rsp_lifetime) && $stable(rsp_preempt))
        else $error("status item changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("command accepted while busy");

    // A change of task always comes from a reschedule, which arms preemption.
    a_switch_preempt: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_switched |-> rsp_preempt)
        else $error("switched task is not preemptable");

    // The busy period lasts at least until the result is registered.
    a_no_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
        else $error("status item appeared too early");

endmodule

bind counter_task_scheduler csched_checker u_csched_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_slot     (rsp.current_slot),
    .rsp_switched (rsp.switched),
    .rsp_lifetime (rsp.current_lifetime),
    .rsp_preempt  (rsp.current_preemptable)
);

`default_nettype wire
